FILE: rtl/lz_backref_stream_decompressor_defines.svh
// ----------------------------------------------------------------------------
// lz_backref_stream_decompressor_defines.svh
// Assertion macros shared by the decompressor RTL.
// ----------------------------------------------------------------------------
`ifndef LZ_BACKREF_STREAM_DECOMPRESSOR_DEFINES_SVH
`define LZ_BACKREF_STREAM_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LZBD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lzbd same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define LZBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lzbd next-cycle check failed");

`endif

FILE: rtl/lzbd_pkg.sv
// ----------------------------------------------------------------------------
// lzbd_pkg
// Shared types and constants of the LZ back-reference decompressor.
// ----------------------------------------------------------------------------
package lzbd_pkg;

    // Tag element kinds (low two bits of a tag byte)
    localparam logic [1:0] TAG_LITERAL = 2'b00;

    // Literal tag values at or above this one announce extension bytes
    localparam logic [5:0] LIT_EXT_MIN  = 6'd60;
    localparam logic [5:0] LIT_EXT_BIAS = 6'd59;

    // Length bias of the short (11-bit offset) copy
    localparam logic [6:0] SHORT_COPY_BIAS = 7'd4;

    // Datapath commands issued by the controller
    typedef struct packed {
        logic busy;        // copy in progress, input held off
        logic tag_load;    // decode tag byte into length and offset fields
        logic ext_load;    // merge one literal length extension byte
        logic lit_pass;    // pass one literal byte out and into history
        logic off_lo;      // capture low offset byte of a long copy
        logic copy_start;  // final offset byte: latch offset and check it
        logic copy_hi;     // final byte is the high offset byte
        logic copy_emit;   // emit one copied byte
        logic clear;       // end of frame: drop history
    } lzbd_cmd_t;

    // Datapath status seen by the controller
    typedef struct packed {
        logic lit_long;    // current tag byte announces extension bytes
        logic lit_last;    // one literal byte left
        logic ext_last;    // one extension byte left
        logic copy_last;   // one copy byte left
        logic out_free;    // output register can take a beat this cycle
    } lzbd_sts_t;

endpackage

FILE: rtl/lzbd_ctrl.sv
// ----------------------------------------------------------------------------
// lzbd_ctrl
// Parse phase tracking and copy sequencing for the decompressor.
// ----------------------------------------------------------------------------
module lzbd_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         data_byte,
    input  logic               end_of_frame,
    input  lzbd_pkg::lzbd_sts_t sts,
    output lzbd_pkg::lzbd_cmd_t cmd
);
    import lzbd_pkg::*;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_TAG    = 3'd1;
    localparam logic [2:0] PH_EXT    = 3'd2;
    localparam logic [2:0] PH_LIT    = 3'd3;
    localparam logic [2:0] PH_OFFS   = 3'd4;
    localparam logic [2:0] PH_OFFLO  = 3'd5;
    localparam logic [2:0] PH_OFFHI  = 3'd6;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [2:0] phase_reg, phase_next;
    logic [1:0] state_reg, state_next;
    logic       eof_pend_reg, eof_pend_next;
    logic       in_fire;

    always_comb
    begin
        phase_next    = phase_reg;
        state_next    = state_reg;
        eof_pend_next = eof_pend_reg;
        cmd           = '0;
        cmd.busy      = (state_reg != ST_IDLE);
        in_ready      = (state_reg == ST_IDLE) && ((phase_reg != PH_LIT) || sts.out_free);
        in_fire       = in_valid && in_ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (phase_reg)
                        PH_HEADER:
                        begin
                            if (!data_byte[7])
                                phase_next = PH_TAG;
                        end
                        PH_TAG:
                        begin
                            cmd.tag_load = 1'b1;
                            if (data_byte[1:0] == TAG_LITERAL)
                                phase_next = sts.lit_long ? PH_EXT : PH_LIT;
                            else if (data_byte[0])
                                phase_next = PH_OFFS;
                            else
                                phase_next = PH_OFFLO;
                        end
                        PH_EXT:
                        begin
                            cmd.ext_load = 1'b1;
                            if (sts.ext_last)
                                phase_next = PH_LIT;
                        end
                        PH_LIT:
                        begin
                            cmd.lit_pass = 1'b1;
                            if (sts.lit_last)
                                phase_next = PH_TAG;
                        end
                        PH_OFFS:
                        begin
                            cmd.copy_start = 1'b1;
                            phase_next     = PH_TAG;
                            state_next     = ST_READ;
                            eof_pend_next  = end_of_frame;
                        end
                        PH_OFFLO:
                        begin
                            cmd.off_lo = 1'b1;
                            phase_next = PH_OFFHI;
                        end
                        PH_OFFHI:
                        begin
                            cmd.copy_start = 1'b1;
                            cmd.copy_hi    = 1'b1;
                            phase_next     = PH_TAG;
                            state_next     = ST_READ;
                            eof_pend_next  = end_of_frame;
                        end
                        default:
                        begin
                            phase_next = PH_HEADER;
                        end
                    endcase
                    // drop a partial element and history at end of frame
                    if (end_of_frame && !cmd.copy_start)
                    begin
                        cmd.clear  = 1'b1;
                        phase_next = PH_HEADER;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.copy_emit = 1'b1;
                    if (sts.copy_last)
                    begin
                        state_next = ST_IDLE;
                        if (eof_pend_reg)
                        begin
                            cmd.clear     = 1'b1;
                            phase_next    = PH_HEADER;
                            eof_pend_next = 1'b0;
                        end
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            state_reg    <= ST_IDLE;
            eof_pend_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            state_reg    <= state_next;
            eof_pend_reg <= eof_pend_next;
        end
    end

endmodule

FILE: rtl/lzbd_dpath.sv
// ----------------------------------------------------------------------------
// lzbd_dpath
// Length and offset registers, history memory and output register.
// ----------------------------------------------------------------------------
module lzbd_dpath
#(
    parameter int WINDOW_BYTES = 65536
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         data_byte,
    input  lzbd_pkg::lzbd_cmd_t cmd,
    output lzbd_pkg::lzbd_sts_t sts,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [7:0]         out_byte,
    output logic               last_of_run,
    output logic               bad_reference
);
    import lzbd_pkg::*;

    localparam int AW = $clog2(WINDOW_BYTES);
    localparam int CW = AW + 1;
    localparam logic [AW-1:0] WP_LAST = AW'(WINDOW_BYTES - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(WINDOW_BYTES);
    localparam logic [16:0]   WIN17 = 17'(WINDOW_BYTES);

    logic [7:0]    hist_mem [WINDOW_BYTES];
    logic [7:0]    rd_data_reg;

    logic [AW-1:0] wp_reg, wp_next;
    logic [CW-1:0] produced_reg, produced_next;
    logic [32:0]   lit_rem_reg, lit_rem_next;
    logic [2:0]    ext_left_reg, ext_left_next;
    logic [1:0]    ext_idx_reg, ext_idx_next;
    logic [15:0]   off_reg, off_next;
    logic [6:0]    len_reg, len_next;
    logic          bad_reg, bad_next;

    logic          out_valid_reg, out_valid_next;
    logic [7:0]    out_byte_reg, out_byte_next;
    logic          out_last_reg, out_last_next;
    logic          out_bad_reg, out_bad_next;

    logic [15:0]   off_final;
    logic [32:0]   lit_merged;
    logic [16:0]   back_sum;
    logic [16:0]   back_wrap;
    logic [AW-1:0] rd_addr;
    logic          hist_we;
    logic [7:0]    hist_wdata;

    assign sts.lit_long  = (data_byte[7:2] >= LIT_EXT_MIN);
    assign sts.lit_last  = (lit_rem_reg == 33'd1);
    assign sts.ext_last  = (ext_left_reg == 3'd1);
    assign sts.copy_last = (len_reg == 7'd1);
    assign sts.out_free  = !out_valid_reg || out_ready;

    assign off_final  = cmd.copy_hi ? {data_byte, off_reg[7:0]} : {off_reg[15:8], data_byte};
    assign lit_merged = lit_rem_reg | (33'(data_byte) << {ext_idx_reg, 3'b000});

    // position of the referenced byte, modulo the window
    assign back_sum  = 17'(wp_reg) + WIN17 - {1'b0, off_reg};
    assign back_wrap = (back_sum >= WIN17) ? (back_sum - WIN17) : back_sum;
    assign rd_addr   = back_wrap[AW-1:0];

    assign hist_we    = cmd.lit_pass || cmd.copy_emit;
    assign hist_wdata = cmd.lit_pass ? data_byte : (bad_reg ? 8'd0 : rd_data_reg);

    always_comb
    begin
        wp_next        = wp_reg;
        produced_next  = produced_reg;
        lit_rem_next   = lit_rem_reg;
        ext_left_next  = ext_left_reg;
        ext_idx_next   = ext_idx_reg;
        off_next       = off_reg;
        len_next       = len_reg;
        bad_next       = bad_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        out_bad_next   = out_bad_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.tag_load)
        begin
            if (data_byte[1:0] == TAG_LITERAL)
            begin
                if (sts.lit_long)
                begin
                    ext_left_next = 3'(data_byte[7:2] - LIT_EXT_BIAS);
                    ext_idx_next  = 2'd0;
                    lit_rem_next  = '0;
                end
                else
                begin
                    lit_rem_next = 33'(data_byte[7:2]) + 33'd1;
                end
            end
            else if (data_byte[0])
            begin
                off_next = {5'd0, data_byte[7:5], 8'd0};
                len_next = 7'(data_byte[4:2]) + SHORT_COPY_BIAS;
            end
            else
            begin
                off_next = '0;
                len_next = 7'(data_byte[7:2]) + 7'd1;
            end
        end

        if (cmd.ext_load)
        begin
            ext_idx_next  = ext_idx_reg + 2'd1;
            ext_left_next = ext_left_reg - 3'd1;
            lit_rem_next  = sts.ext_last ? (lit_merged + 33'd1) : lit_merged;
        end

        if (cmd.off_lo)
            off_next = {8'd0, data_byte};

        if (cmd.copy_start)
        begin
            off_next = off_final;
            bad_next = (off_final == 16'd0) || (17'(off_final) > 17'(produced_reg));
        end

        if (cmd.lit_pass)
        begin
            lit_rem_next   = lit_rem_reg - 33'd1;
            out_byte_next  = data_byte;
            out_last_next  = 1'b1;
            out_bad_next   = 1'b0;
            out_valid_next = 1'b1;
        end

        if (cmd.copy_emit)
        begin
            len_next       = len_reg - 7'd1;
            out_byte_next  = hist_wdata;
            out_last_next  = sts.copy_last;
            out_bad_next   = bad_reg;
            out_valid_next = 1'b1;
        end

        // every produced byte advances the window
        if (hist_we)
        begin
            wp_next = (wp_reg == WP_LAST) ? '0 : (wp_reg + AW'(1));
            if (produced_reg != CNT_FULL)
                produced_next = produced_reg + CW'(1);
        end

        if (cmd.clear)
        begin
            wp_next       = '0;
            produced_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            produced_reg  <= '0;
            lit_rem_reg   <= '0;
            ext_left_reg  <= '0;
            ext_idx_reg   <= '0;
            off_reg       <= '0;
            len_reg       <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wp_reg        <= wp_next;
            produced_reg  <= produced_next;
            lit_rem_reg   <= lit_rem_next;
            ext_left_reg  <= ext_left_next;
            ext_idx_reg   <= ext_idx_next;
            off_reg       <= off_next;
            len_reg       <= len_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
        out_bad_reg  <= out_bad_next;
    end

    // history window: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[wp_reg] <= hist_wdata;
        rd_data_reg <= hist_mem[rd_addr];
    end

    assign out_valid     = out_valid_reg;
    assign out_byte      = out_byte_reg;
    assign last_of_run   = out_last_reg;
    assign bad_reference = out_bad_reg;

endmodule

FILE: rtl/lz_backref_stream_decompressor.sv
// ----------------------------------------------------------------------------
// lz_backref_stream_decompressor
// Byte-serial LZ77 decompressor for the varint-header, tagged-element format.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes one compressed byte per beat with
// end_of_frame marking the last byte of a frame; the frame's parser state
// and history are dropped after that byte. Output channel (out_valid/
// out_ready) delivers one decompressed byte per beat, with last_of_run on
// the final byte caused by one input byte and bad_reference on bytes of a
// copy whose offset is zero or points before the start of the frame.
// Header, tag, extension and offset bytes give no beat. A literal byte
// gives one beat in the next cycle, from the output register. A copy of N
// bytes starts on its last offset byte and runs byte by byte: each byte
// needs a registered history read before its emit and write-back, since an
// overlapping copy reads the byte written just before it.
// Input is held off for the whole copy.
// The output register lets the next input byte in while a beat waits; when
// the receiver stalls, literal bytes and copy steps wait for that register.
// Reset clears parser and copy control; the history memory is not cleared,
// as only bytes already produced in the frame can be referenced.
// ----------------------------------------------------------------------------
`include "lz_backref_stream_decompressor_defines.svh"

module lz_backref_stream_decompressor
#(
    parameter int WINDOW_BYTES = 65536
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    input  logic       end_of_frame,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       last_of_run,
    output logic       bad_reference
);
    import lzbd_pkg::*;

    lzbd_cmd_t cmd;
    lzbd_sts_t sts;

    // Phase tracking and copy sequencing
    lzbd_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .end_of_frame (end_of_frame),
        .sts          (sts),
        .cmd          (cmd)
    );

    // Length/offset registers, history window and output register
    lzbd_dpath
    #(
        .WINDOW_BYTES (WINDOW_BYTES)
    )
    u_dpath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .data_byte     (data_byte),
        .cmd           (cmd),
        .sts           (sts),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_of_run   (last_of_run),
        .bad_reference (bad_reference)
    );

    // Hold input off while a copy runs
    `LZBD_ASSERT_NOW(a_busy_blocks_input, cmd.busy, !in_ready)
    // Never overwrite a waiting beat
    `LZBD_ASSERT_NOW(a_emit_needs_room, cmd.copy_emit || cmd.lit_pass, sts.out_free)
    // A produced byte always shows up as a beat next cycle
    `LZBD_ASSERT_NEXT(a_emit_shows_beat, cmd.copy_emit || cmd.lit_pass, out_valid)

endmodule
